@@ hw/rtl/mese_pkg.sv @@
package mese_pkg;

    localparam int FUNC_W  = 4;
    localparam int CHAN_W  = 8;
    localparam int DATA_A_W = 14;
    localparam int DATA_B_W = 8;
    localparam int TIME_W  = 32;
    localparam int TPQ_W   = 15;
    localparam int RATE_W  = 18;
    localparam int TEMPO_W = 24;
    localparam int DEN_W   = 35;   // ticks per quarter times one million
    localparam int MUL_W   = 42;   // tempo times sample rate
    localparam int DELTA_W = 28;
    localparam int LEN_W   = 6;    // byte count of one transaction, up to 37
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    localparam int IN_DEPTH_DEF = 2;

    localparam logic [TPQ_W-1:0]   TPQ_RESET   = 15'd144;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd44100;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 24'd500000;
    localparam logic [DELTA_W-1:0] DELTA_SAT   = 28'hFFFFFFF;
    localparam logic [TIME_W-1:0]  START_TRACK_BYTES = 32'd15;
    localparam logic [LEN_W-1:0]   START_LEN   = 6'd37;

    localparam logic [FUNC_W-1:0] FN_START     = 4'd0;
    localparam logic [FUNC_W-1:0] FN_NOTEOFF   = 4'd1;
    localparam logic [FUNC_W-1:0] FN_NOTEON    = 4'd2;
    localparam logic [FUNC_W-1:0] FN_KEYPRESS  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_CONTROL   = 4'd4;
    localparam logic [FUNC_W-1:0] FN_PROGRAM   = 4'd5;
    localparam logic [FUNC_W-1:0] FN_CHANPRESS = 4'd6;
    localparam logic [FUNC_W-1:0] FN_BEND      = 4'd7;
    localparam logic [FUNC_W-1:0] FN_TEMPO     = 4'd8;
    localparam logic [FUNC_W-1:0] FN_TIMESIG   = 4'd9;
    localparam logic [FUNC_W-1:0] FN_END       = 4'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_TPQ  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE = 1'd1;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [CHAN_W-1:0]   chan;
        logic [DATA_A_W-1:0] data_a;
        logic [DATA_B_W-1:0] data_b;
        logic [TIME_W-1:0]   event_time;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              last;
        logic [TIME_W-1:0] track_length;
    } t_out_item;

    // classified event as it waits between front and back
    typedef struct packed {
        t_in_item         item;
        logic             has_delta;
        logic [LEN_W-1:0] body_len;
        logic [2:0]       tz;
    } t_cls_item;

    // request to the multiply-divide unit: (a * b + c) / dv
    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [MUL_W-1:0]  b;
        logic [DEN_W-1:0]  c;
        logic [MUL_W-1:0]  dv;
    } t_md_req;

    typedef struct packed {
        logic [TIME_W-1:0] q;
        logic              sat;
        logic [MUL_W-1:0]  rem;
    } t_md_rsp;

endpackage

@@ hw/rtl/mese_front.sv @@
module mese_front import mese_pkg::*; #(
    parameter int IN_DEPTH = IN_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_cls_item o_head,
    input  logic      i_take
);

    localparam int PTR_W = $clog2(IN_DEPTH);
    localparam int CNT_W = $clog2(IN_DEPTH + 1);

    t_cls_item            r_mem [IN_DEPTH];
    logic [PTR_W-1:0]     r_wr, r_rd;
    logic [CNT_W-1:0]     r_cnt;
    t_cls_item            n_cls;
    logic                 drop;
    logic                 do_wr, do_rd;

    // classify: byte count of the body, whether a delta precedes it
    always_comb begin
        n_cls           = '0;
        n_cls.item      = i_item;
        n_cls.has_delta = 1'b0;
        n_cls.body_len  = '0;
        n_cls.tz        = '0;
        drop            = 1'b0;
        for (int k = 7; k >= 0; k--) begin
            if (i_item.data_b[k]) begin
                n_cls.tz = 3'(k);
            end
        end
        case (i_item.func)
            FN_START: begin
                n_cls.body_len = START_LEN;
            end
            FN_NOTEOFF, FN_NOTEON, FN_KEYPRESS, FN_CONTROL, FN_BEND: begin
                n_cls.has_delta = 1'b1;
                n_cls.body_len  = 6'd3;
            end
            FN_PROGRAM, FN_CHANPRESS: begin
                n_cls.has_delta = 1'b1;
                n_cls.body_len  = 6'd2;
            end
            FN_TEMPO: begin
                n_cls.has_delta = 1'b1;
                n_cls.body_len  = 6'd6;
            end
            FN_TIMESIG: begin
                if (i_item.chan == '0) begin
                    n_cls.has_delta = 1'b1;
                    n_cls.body_len  = 6'd5;
                    drop            = (i_item.data_b == '0);
                end else begin
                    n_cls.body_len = 6'd2;
                end
            end
            FN_END: begin
                n_cls.body_len = 6'd4;
            end
            default: begin
                drop = 1'b1;
            end
        endcase
    end

    assign full    = (r_cnt == CNT_W'(IN_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_wr   = push && !full && !drop;
    assign do_rd   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr] <= n_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wr <= (r_wr == PTR_W'(IN_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_rd) begin
                r_rd <= (r_rd == PTR_W'(IN_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/mese_muldiv.sv @@
module mese_muldiv import mese_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_md_req i_req,
    output logic    o_done,
    output t_md_rsp o_rsp
);

    localparam int ACC_W = TIME_W + MUL_W + 1;

    localparam logic [1:0] MD_IDLE = 2'd0;
    localparam logic [1:0] MD_MUL  = 2'd1;
    localparam logic [1:0] MD_ADD  = 2'd2;
    localparam logic [1:0] MD_DIV  = 2'd3;

    logic [1:0]        r_state;
    logic [6:0]        r_cnt;
    logic [TIME_W-1:0] r_a;
    logic [MUL_W-1:0]  r_b, r_dv, r_rem;
    logic [DEN_W-1:0]  r_c;
    logic [ACC_W-1:0]  r_acc;
    logic [TIME_W-1:0] r_q;
    logic              r_sat, r_done;
    logic [MUL_W:0]    trial;
    logic [MUL_W+1:0]  diff;
    logic              qbit;

    assign trial = {r_rem, r_acc[ACC_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_dv};
    assign qbit  = !diff[MUL_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                MD_IDLE: begin
                    if (i_start) begin
                        r_state <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    if (r_cnt == '0) begin
                        r_state <= MD_ADD;
                    end
                end
                MD_ADD: begin
                    r_state <= MD_DIV;
                end
                MD_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= MD_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= MD_IDLE;
                end
            endcase
        end
    end

    // msb-first shift-add product, add of c, then restoring division one bit a cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            MD_IDLE: begin
                if (i_start) begin
                    r_a   <= i_req.a;
                    r_b   <= i_req.b;
                    r_c   <= i_req.c;
                    r_dv  <= i_req.dv;
                    r_acc <= '0;
                    r_cnt <= 7'(TIME_W - 1);
                end
            end
            MD_MUL: begin
                r_acc <= {r_acc[ACC_W-2:0], 1'b0}
                       + (r_a[TIME_W-1] ? ACC_W'(r_b) : '0);
                r_a   <= {r_a[TIME_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            MD_ADD: begin
                r_acc <= r_acc + ACC_W'(r_c);
                r_cnt <= 7'(ACC_W - 1);
                r_rem <= '0;
                r_q   <= '0;
                r_sat <= 1'b0;
            end
            MD_DIV: begin
                r_rem <= qbit ? diff[MUL_W-1:0] : trial[MUL_W-1:0];
                r_acc <= {r_acc[ACC_W-2:0], 1'b0};
                r_q   <= {r_q[TIME_W-2:0], qbit};
                r_sat <= r_sat | (qbit && (r_cnt >= 7'(DELTA_W)));
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_done    = r_done;
    assign o_rsp.q   = r_q;
    assign o_rsp.sat = r_sat;
    assign o_rsp.rem = r_rem;

endmodule

@@ hw/rtl/mese_back.sv @@
module mese_back import mese_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TPQ_W-1:0]  i_tpq,
    input  logic [RATE_W-1:0] i_rate,
    input  logic              i_clr_res,
    input  logic              i_valid,
    input  t_cls_item         i_head,
    output logic              o_take,
    output logic              empty,
    input  logic              pop,
    output t_out_item         o_result
);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_PREP  = 3'd1;
    localparam logic [2:0] B_DIV1  = 3'd2;
    localparam logic [2:0] B_DIV2  = 3'd3;
    localparam logic [2:0] B_SETUP = 3'd4;
    localparam logic [2:0] B_EMIT  = 3'd5;

    logic [2:0]         r_state;
    t_cls_item          r_cur;
    logic [DEN_W-1:0]   r_den;
    logic [MUL_W-1:0]   r_mul;
    logic [TIME_W-1:0]  r_w;
    logic [DEN_W-1:0]   r_r;
    logic [TEMPO_W-1:0] r_tempo;
    logic [TIME_W-1:0]  r_track;
    logic [DELTA_W-1:0] r_delta;
    logic [2:0]         r_nd;
    logic [LEN_W-1:0]   r_n, r_idx;
    logic               r_out_valid;
    t_out_item          r_out;
    logic               r_md_start;
    t_md_req            r_md_req;
    logic               md_done;
    t_md_rsp            md_rsp;
    logic [TIME_W-1:0]  samp_dist;
    logic [6:0]         grp [4];
    logic [2:0]         n_nd;
    logic [DELTA_W-1:0] n_delta;
    logic               slot_free;
    logic [7:0]         n_byte;
    logic [LEN_W-1:0]   k;
    logic [2:0]         gsel;
    logic [3:0]         st;

    mese_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_md_start),
        .i_req   (r_md_req),
        .o_done  (md_done),
        .o_rsp   (md_rsp)
    );

    // truncated sample distance since the exact last time
    always_comb begin
        samp_dist = '0;
        if (r_cur.item.event_time > r_w) begin
            samp_dist = r_cur.item.event_time - r_w - TIME_W'(r_r != '0);
        end
    end

    assign n_delta = md_rsp.sat ? DELTA_SAT : md_rsp.q[DELTA_W-1:0];

    always_comb begin
        grp[0] = r_delta[27:21];
        grp[1] = r_delta[20:14];
        grp[2] = r_delta[13:7];
        grp[3] = r_delta[6:0];
        if (!r_cur.has_delta) begin
            n_nd = 3'd0;
        end else if (grp[0] != '0) begin
            n_nd = 3'd4;
        end else if (grp[1] != '0) begin
            n_nd = 3'd3;
        end else if (grp[2] != '0) begin
            n_nd = 3'd2;
        end else begin
            n_nd = 3'd1;
        end
    end

    // byte generator
    always_comb begin
        k      = r_idx - LEN_W'(r_nd);
        gsel   = 3'd4 - r_nd + r_idx[2:0];
        st     = r_cur.item.chan[3:0];
        n_byte = '0;
        if (r_idx < LEN_W'(r_nd)) begin
            n_byte = {(r_idx != LEN_W'(r_nd) - 1'b1), grp[gsel[1:0]]};
        end else begin
            case (r_cur.item.func)
                FN_START: begin
                    case (k)
                        6'd0:  n_byte = 8'h4D;
                        6'd1:  n_byte = 8'h54;
                        6'd2:  n_byte = 8'h68;
                        6'd3:  n_byte = 8'h64;
                        6'd7:  n_byte = 8'h06;
                        6'd11: n_byte = 8'h01;
                        6'd12: n_byte = {1'b0, i_tpq[14:8]};
                        6'd13: n_byte = i_tpq[7:0];
                        6'd14: n_byte = 8'h4D;
                        6'd15: n_byte = 8'h54;
                        6'd16: n_byte = 8'h72;
                        6'd17: n_byte = 8'h6B;
                        6'd18: n_byte = 8'h7F;
                        6'd19, 6'd20, 6'd21, 6'd23: n_byte = 8'hFF;
                        6'd24: n_byte = 8'h51;
                        6'd25: n_byte = 8'h03;
                        6'd26: n_byte = TEMPO_RESET[23:16];
                        6'd27: n_byte = TEMPO_RESET[15:8];
                        6'd28: n_byte = TEMPO_RESET[7:0];
                        6'd30: n_byte = 8'hFF;
                        6'd31: n_byte = 8'h58;
                        6'd32, 6'd33: n_byte = 8'h04;
                        6'd34: n_byte = 8'h02;
                        6'd35: n_byte = 8'h18;
                        6'd36: n_byte = 8'h08;
                        default: n_byte = 8'h00;
                    endcase
                end
                FN_NOTEOFF, FN_NOTEON, FN_KEYPRESS, FN_CONTROL, FN_PROGRAM,
                FN_CHANPRESS, FN_BEND: begin
                    case (k)
                        6'd0:    n_byte = {1'b1, 3'(r_cur.item.func - 4'd1), st};
                        6'd1:    n_byte = {1'b0, r_cur.item.data_a[6:0]};
                        default: n_byte = (r_cur.item.func == FN_BEND)
                                        ? {1'b0, r_cur.item.data_a[13:7]}
                                        : {1'b0, r_cur.item.data_b[6:0]};
                    endcase
                end
                FN_TEMPO: begin
                    case (k)
                        6'd0:    n_byte = 8'hFF;
                        6'd1:    n_byte = 8'h51;
                        6'd2:    n_byte = 8'h03;
                        6'd3:    n_byte = r_tempo[23:16];
                        6'd4:    n_byte = r_tempo[15:8];
                        default: n_byte = r_tempo[7:0];
                    endcase
                end
                FN_TIMESIG: begin
                    if (r_cur.has_delta) begin
                        case (k)
                            6'd0:    n_byte = 8'hFF;
                            6'd1:    n_byte = 8'h58;
                            6'd2:    n_byte = 8'h04;
                            6'd3:    n_byte = r_cur.item.data_a[7:0];
                            default: n_byte = {5'd0, r_cur.tz};
                        endcase
                    end else begin
                        n_byte = (k == '0) ? r_cur.item.data_a[7:0] : r_cur.item.data_b;
                    end
                end
                FN_END: begin
                    case (k)
                        6'd1:    n_byte = 8'hFF;
                        6'd2:    n_byte = 8'h2F;
                        default: n_byte = 8'h00;
                    endcase
                end
                default: n_byte = 8'h00;
            endcase
        end
    end

    assign slot_free = !r_out_valid || pop;
    assign o_take    = (r_state == B_IDLE);
    assign empty     = !r_out_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_md_start  <= 1'b0;
            r_w         <= '0;
            r_r         <= '0;
            r_tempo     <= TEMPO_RESET;
            r_track     <= '0;
        end else begin
            r_md_start <= 1'b0;
            r_den      <= DEN_W'(i_tpq) * DEN_W'(20'd1000000);
            r_mul      <= MUL_W'(r_tempo) * MUL_W'(i_rate);
            if (i_clr_res) begin
                r_r <= '0;
            end
            if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        r_cur   <= i_head;
                        r_state <= B_PREP;
                    end
                end
                B_PREP: begin
                    r_delta <= '0;
                    r_state <= B_SETUP;
                    if (r_cur.item.func == FN_START) begin
                        r_w     <= '0;
                        r_r     <= '0;
                        r_tempo <= TEMPO_RESET;
                    end else if (r_cur.has_delta && r_den != '0 && samp_dist != '0) begin
                        if (r_mul == '0) begin
                            r_delta <= DELTA_SAT;
                        end else begin
                            r_md_req   <= '{a: samp_dist, b: MUL_W'(r_den), c: '0,
                                            dv: r_mul};
                            r_md_start <= 1'b1;
                            r_state    <= B_DIV1;
                        end
                    end
                end
                B_DIV1: begin
                    if (md_done) begin
                        r_delta <= n_delta;
                        if (n_delta == '0) begin
                            r_state <= B_SETUP;
                        end else begin
                            r_md_req   <= '{a: TIME_W'(n_delta), b: r_mul, c: r_r,
                                            dv: MUL_W'(r_den)};
                            r_md_start <= 1'b1;
                            r_state    <= B_DIV2;
                        end
                    end
                end
                B_DIV2: begin
                    if (md_done) begin
                        r_w     <= r_w + md_rsp.q;
                        r_r     <= md_rsp.rem[DEN_W-1:0];
                        r_state <= B_SETUP;
                    end
                end
                B_SETUP: begin
                    r_nd  <= n_nd;
                    r_n   <= LEN_W'(n_nd) + r_cur.body_len;
                    r_idx <= '0;
                    if (r_cur.item.func == FN_TEMPO) begin
                        r_tempo <= {r_cur.item.data_a[7:0], r_cur.item.data_b,
                                    r_cur.item.chan};
                    end
                    if (r_cur.item.func == FN_START) begin
                        r_track <= START_TRACK_BYTES;
                    end else begin
                        r_track <= r_track + TIME_W'(LEN_W'(n_nd) + r_cur.body_len);
                    end
                    r_state <= B_EMIT;
                end
                B_EMIT: begin
                    if (slot_free) begin
                        r_out_valid           <= 1'b1;
                        r_out.out_byte        <= n_byte;
                        r_out.last            <= (r_idx == r_n - 1'b1);
                        r_out.track_length    <= ((r_idx == r_n - 1'b1)
                                                  && r_cur.item.func == FN_END)
                                                 ? r_track : '0;
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == r_n - 1'b1) begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/midi_event_stream_encoder_core.sv @@
// single-track standard midi file writer. each input transaction is one timed
// midi request and produces the bytes it appends to the file, one byte per
// result transaction with last set on the final byte; a start transaction
// writes the file and track headers plus default tempo and 4/4 time signature
// (37 bytes), an end transaction writes end-of-track and shows the track byte
// count on its last byte. an event with a time delta runs up to two
// shift-add/restoring-division passes on one shared unit and then emits its
// bytes at one per cycle while the output is not stalled; start, end and later
// timesig parts emit their bytes with no division pass. an input queue of
// IN_DEPTH entries (two by default) lets the next transaction be taken while
// one is in the back end, and an output register holds the oldest byte.
// configuration must be written only while idle; the block itself does not
// enforce this. writing ticks_per_quarter also clears the fractional time residue
module midi_event_stream_encoder_core import mese_pkg::*; #(
    parameter int IN_DEPTH = IN_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_result
);

    // configuration registers
    logic [TPQ_W-1:0]  r_tpq;
    logic [RATE_W-1:0] r_rate;
    logic              clr_res;

    // front to back handoff
    logic      head_valid;
    t_cls_item head;
    logic      take;

    assign clr_res = i_cfg_we && (i_cfg_idx == CFG_TPQ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpq  <= TPQ_RESET;
            r_rate <= RATE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TPQ:  r_tpq  <= i_cfg_data[TPQ_W-1:0];
                CFG_RATE: r_rate <= i_cfg_data[RATE_W-1:0];
                default:  r_tpq  <= r_tpq;
            endcase
        end
    end

    // front: classifies each event and queues it, drops those with no bytes
    mese_front #(
        .IN_DEPTH (IN_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .o_valid (head_valid),
        .o_head  (head),
        .i_take  (take)
    );

    // back: timing arithmetic, state update and byte emission
    mese_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tpq     (r_tpq),
        .i_rate    (r_rate),
        .i_clr_res (clr_res),
        .i_valid   (head_valid),
        .i_head    (head),
        .o_take    (take),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule

@@ hw/rtl/mese_checker.sv @@
module mese_checker import mese_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      empty,
    input logic      pop,
    input t_out_item o_result
);

    // nothing to pop right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // a track length only shows on the final byte of a transaction
    a_len_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.track_length != '0) |-> o_result.last)
        else $error("track length on a non-final byte");

    // bytes of one transaction follow without a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_result.last) |=> !empty)
        else $error("gap inside a byte run");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("stalled result changed");

endmodule

bind midi_event_stream_encoder_core mese_checker u_mese_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import mese_pkg::*;

    // first code past the defined functions; everything up to 15 is unused
    localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 4'd11;
    localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 4'd15;
    localparam int NUM_PHASES  = 5;
    localparam int SETTLE_CYC  = 400;      // longer than one timed event in the back end
    localparam int CYCLE_LIMIT = 3000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  push;
    logic                  full;
    t_in_item              i_item;
    logic                  empty;
    logic                  pop;
    t_out_item             o_result;

    midi_event_stream_encoder_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    // clock, 12 ns period
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // pending events for the driver and the file bytes still owed by the block
    t_in_item  event_q[$];
    t_out_item file_byte_q[$];
    int        mismatch_cnt = 0;
    int        cycle_cnt = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    // encoder state as predicted
    logic [TPQ_W-1:0]   pr_tpq;
    logic [RATE_W-1:0]  pr_rate;
    logic [31:0]        pr_whole;
    logic [63:0]        pr_resid;
    logic [TEMPO_W-1:0] pr_tempo;
    logic [31:0]        pr_track_bytes;

    // bytes of the transaction being predicted
    logic [7:0] stream_bytes[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    // tick delta from the exact rational last time, then advance that time
    task automatic emit_delta(input logic [31:0] ev_time);
        logic [127:0] den;
        logic [127:0] mul;
        logic [127:0] samp_dist;
        logic [127:0] quo;
        logic [127:0] acc;
        logic [27:0]  delta;
        logic [6:0]   grp[4];
        logic         started;
        den  = 128'(pr_tpq) * 128'd1000000;
        mul  = 128'(pr_tempo) * 128'(pr_rate);
        samp_dist = '0;
        if (ev_time > pr_whole)
            samp_dist = 128'(ev_time - pr_whole) - ((pr_resid != 0) ? 128'd1 : 128'd0);
        if (den == 0 || samp_dist == 0) begin
            delta = '0;
        end else if (mul == 0) begin
            delta = DELTA_SAT;
        end else begin
            quo = (samp_dist * den) / mul;
            delta = (quo > 128'(DELTA_SAT)) ? DELTA_SAT : quo[27:0];
        end
        if (delta != 0 && den != 0) begin
            acc = 128'(delta) * mul + 128'(pr_resid);
            pr_whole = pr_whole + 32'(acc / den);
            pr_resid = 64'(acc % den);
        end
        grp[0] = delta[27:21];
        grp[1] = delta[20:14];
        grp[2] = delta[13:7];
        grp[3] = delta[6:0];
        started = 1'b0;
        for (int g = 0; g < 3; g++) begin
            if (started || grp[g] != 0) begin
                started = 1'b1;
                stream_bytes.push_back({1'b1, grp[g]});
            end
        end
        stream_bytes.push_back({1'b0, grp[3]});
    endtask

    task automatic emit_tempo_meta();
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(8'h51);
        stream_bytes.push_back(8'h03);
        stream_bytes.push_back(pr_tempo[23:16]);
        stream_bytes.push_back(pr_tempo[15:8]);
        stream_bytes.push_back(pr_tempo[7:0]);
    endtask

    // predict the file bytes one accepted event appends
    task automatic predict_file_bytes(input t_in_item ev);
        logic [3:0] status_lo;
        logic [7:0] den_b;
        int         lowbit;
        t_out_item  res;
        stream_bytes = {};
        status_lo = ev.chan[3:0];
        case (ev.func)
            FN_START: begin
                stream_bytes = '{8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06,
                                 8'h00, 8'h00, 8'h00, 8'h01};
                stream_bytes.push_back(8'(pr_tpq >> 8));
                stream_bytes.push_back(pr_tpq[7:0]);
                stream_bytes.push_back(8'h4D);
                stream_bytes.push_back(8'h54);
                stream_bytes.push_back(8'h72);
                stream_bytes.push_back(8'h6B);
                stream_bytes.push_back(8'h7F);
                stream_bytes.push_back(8'hFF);
                stream_bytes.push_back(8'hFF);
                stream_bytes.push_back(8'hFF);
                pr_whole = '0;
                pr_resid = '0;
                pr_tempo = TEMPO_RESET;
                emit_delta(32'd0);
                emit_tempo_meta();
                emit_delta(32'd0);
                stream_bytes.push_back(8'hFF);
                stream_bytes.push_back(8'h58);
                stream_bytes.push_back(8'h04);
                stream_bytes.push_back(8'h04);
                stream_bytes.push_back(8'h02);
                stream_bytes.push_back(8'h18);
                stream_bytes.push_back(8'h08);
            end
            FN_NOTEOFF, FN_NOTEON, FN_KEYPRESS, FN_CONTROL: begin
                emit_delta(ev.event_time);
                stream_bytes.push_back({4'(4'h8 + ev.func - FN_NOTEOFF), status_lo});
                stream_bytes.push_back({1'b0, ev.data_a[6:0]});
                stream_bytes.push_back({1'b0, ev.data_b[6:0]});
            end
            FN_PROGRAM, FN_CHANPRESS: begin
                emit_delta(ev.event_time);
                stream_bytes.push_back({(ev.func == FN_PROGRAM) ? 4'hC : 4'hD, status_lo});
                stream_bytes.push_back({1'b0, ev.data_a[6:0]});
            end
            FN_BEND: begin
                emit_delta(ev.event_time);
                stream_bytes.push_back({4'hE, status_lo});
                stream_bytes.push_back({1'b0, ev.data_a[6:0]});
                stream_bytes.push_back({1'b0, ev.data_a[13:7]});
            end
            FN_TEMPO: begin
                // delta still at the old tempo
                emit_delta(ev.event_time);
                pr_tempo = {ev.data_a[7:0], ev.data_b, ev.chan};
                emit_tempo_meta();
            end
            FN_TIMESIG: begin
                den_b = ev.data_b;
                if (ev.chan == 0) begin
                    if (ev.data_b != 0) begin
                        lowbit = 0;
                        while (!ev.data_b[lowbit])
                            lowbit++;
                        emit_delta(ev.event_time);
                        stream_bytes.push_back(8'hFF);
                        stream_bytes.push_back(8'h58);
                        stream_bytes.push_back(8'h04);
                        den_b = 8'(lowbit);
                    end
                end
                // first part with zero denominator gives nothing
                if (ev.chan != 0 || ev.data_b != 0) begin
                    stream_bytes.push_back(ev.data_a[7:0]);
                    stream_bytes.push_back(den_b);
                end
            end
            FN_END: begin
                stream_bytes = '{8'h00, 8'hFF, 8'h2F, 8'h00};
            end
            default: ;
        endcase
        if (ev.func == FN_START)
            pr_track_bytes = 32'(stream_bytes.size() - 22);
        else if (ev.func >= FN_NOTEOFF && ev.func <= FN_END)
            pr_track_bytes = pr_track_bytes + 32'(stream_bytes.size());
        foreach (stream_bytes[k]) begin
            res.out_byte     = stream_bytes[k];
            res.last         = (k == stream_bytes.size() - 1);
            res.track_length = (res.last && ev.func == FN_END) ? pr_track_bytes : '0;
            file_byte_q.push_back(res);
        end
    endtask

    // driver: new values at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            pop  <= 1'b0;
        end else begin
            push   <= (event_q.size() > 0) && ($urandom_range(99) >= send_idle_pct);
            if (event_q.size() > 0)
                i_item <= event_q[0];
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: input and output transactions seen at the rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && push && !full) begin
            predict_file_bytes(i_item);
            void'(event_q.pop_front());
        end
        if (i_rst_n && pop && !empty) begin
            if (file_byte_q.size() == 0) begin
                report("unexpected byte", 32'(o_result.out_byte), 32'hx);
            end else begin
                want = file_byte_q.pop_front();
                if (o_result.out_byte !== want.out_byte)
                    report("out_byte", 32'(o_result.out_byte), 32'(want.out_byte));
                if (o_result.last !== want.last)
                    report("last", 32'(o_result.last), 32'(want.last));
                if (o_result.track_length !== want.track_length)
                    report("track_length", o_result.track_length, want.track_length);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_in_item mk_event(input logic [FUNC_W-1:0] fn, input logic [7:0] ch,
                                          input logic [13:0] da, input logic [7:0] db,
                                          input logic [31:0] tm);
        t_in_item ev;
        ev.func       = fn;
        ev.chan       = ch;
        ev.data_a     = da;
        ev.data_b     = db;
        ev.event_time = tm;
        return ev;
    endfunction

    // wait for the block to drain, then give the back end time to settle
    task automatic wait_idle();
        while (event_q.size() > 0 || file_byte_q.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TPQ) begin
            pr_tpq   = val[TPQ_W-1:0];
            pr_resid = '0;
        end else begin
            pr_rate = val[RATE_W-1:0];
        end
    endtask

    // random time step: mostly short, sometimes long, rarely anywhere
    function automatic logic [31:0] time_step();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return $urandom_range(3000);
        else if (sel < 95)
            return $urandom_range(300000);
        return $urandom;
    endfunction

    // well-formed tracks with random content, with some noise mixed in
    task automatic queue_random_events(input int count);
        logic [31:0]       now;
        int                sel;
        logic [FUNC_W-1:0] fn;
        logic [7:0]        den;
        now = '0;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 7) begin
                event_q.push_back(mk_event(FN_START, $urandom, $urandom, $urandom, $urandom));
                now = '0;
            end else if (sel < 12) begin
                event_q.push_back(mk_event(FN_END, $urandom, $urandom, $urandom, $urandom));
            end else if (sel < 15) begin
                fn = 4'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
                event_q.push_back(mk_event(fn, $urandom, $urandom, $urandom, $urandom));
            end else if (sel < 19) begin
                // time going backwards
                event_q.push_back(mk_event(4'($urandom_range(FN_NOTEOFF, FN_BEND)), $urandom,
                                           $urandom, $urandom, $urandom_range(now)));
            end else begin
                now = now + time_step();
                fn = 4'($urandom_range(FN_NOTEOFF, FN_TIMESIG));
                if (fn == FN_TIMESIG) begin
                    den = ($urandom_range(9) == 0) ? 8'($urandom) : 8'(1 << $urandom_range(7));
                    event_q.push_back(mk_event(FN_TIMESIG, 8'd0, $urandom, den, now));
                    event_q.push_back(mk_event(FN_TIMESIG, 8'($urandom_range(1, 255)),
                                               $urandom, $urandom, now));
                    n++;
                end else begin
                    event_q.push_back(mk_event(fn, $urandom, $urandom, $urandom, now));
                end
            end
        end
    endtask

    task automatic queue_directed_events();
        // before any start
        event_q.push_back(mk_event(FN_NOTEON, 8'h03, 14'd60, 8'd100, 32'd100));
        event_q.push_back(mk_event(FN_START, 8'h00, 14'd0, 8'd0, 32'd0));
        // field extremes and every channel event
        event_q.push_back(mk_event(FN_NOTEOFF, 8'hFF, 14'h3FFF, 8'hFF, 32'd44100));
        event_q.push_back(mk_event(FN_NOTEON, 8'h00, 14'd0, 8'd0, 32'd44100));
        event_q.push_back(mk_event(FN_KEYPRESS, 8'h5A, 14'h2AD5, 8'hA5, 32'd50000));
        event_q.push_back(mk_event(FN_CONTROL, 8'hA5, 14'h152A, 8'h5A, 32'd60001));
        event_q.push_back(mk_event(FN_PROGRAM, 8'h0F, 14'h3FFF, 8'hFF, 32'd70000));
        event_q.push_back(mk_event(FN_CHANPRESS, 8'hF0, 14'h007F, 8'h00, 32'd70123));
        event_q.push_back(mk_event(FN_BEND, 8'h01, 14'h3FFF, 8'h00, 32'd80000));
        event_q.push_back(mk_event(FN_BEND, 8'h02, 14'h2A55, 8'h00, 32'd90000));
        // time going backwards
        event_q.push_back(mk_event(FN_NOTEON, 8'h04, 14'd1, 8'd1, 32'd10));
        // tempo extremes, then saturated delta at tempo one and at tempo zero
        event_q.push_back(mk_event(FN_TEMPO, 8'hFF, 14'h3FFF, 8'hFF, 32'd100000));
        event_q.push_back(mk_event(FN_TEMPO, 8'h01, 14'h0000, 8'h00, 32'd100000));
        event_q.push_back(mk_event(FN_NOTEON, 8'h05, 14'd2, 8'd2, 32'hFFFFFFFF));
        event_q.push_back(mk_event(FN_TEMPO, 8'h00, 14'h0000, 8'h00, 32'hFFFFFFFF));
        event_q.push_back(mk_event(FN_NOTEOFF, 8'h05, 14'd2, 8'd2, 32'hFFFFFFFF));
        // time signature: first part, zero denominator, later part
        event_q.push_back(mk_event(FN_START, 8'h00, 14'd0, 8'd0, 32'd0));
        event_q.push_back(mk_event(FN_TIMESIG, 8'h00, 14'd3, 8'd8, 32'd1000));
        event_q.push_back(mk_event(FN_TIMESIG, 8'h00, 14'd7, 8'd0, 32'd2000));
        event_q.push_back(mk_event(FN_TIMESIG, 8'h00, 14'h3FFF, 8'h80, 32'd3000));
        event_q.push_back(mk_event(FN_TIMESIG, 8'hFF, 14'h00FF, 8'hFF, 32'd3000));
        // unused codes
        event_q.push_back(mk_event(FN_SPARE_FIRST, 8'h11, 14'd5, 8'd5, 32'd4000));
        event_q.push_back(mk_event(FN_SPARE_LAST, 8'hFF, 14'h3FFF, 8'hFF, 32'hFFFFFFFF));
        event_q.push_back(mk_event(FN_END, 8'h00, 14'd0, 8'd0, 32'd5000));
        // after the end
        event_q.push_back(mk_event(FN_CONTROL, 8'h09, 14'd64, 8'd127, 32'd6000));
    endtask

    initial begin
        // per phase: register values and idling
        logic [TPQ_W-1:0]  tpq_set[NUM_PHASES]  = '{15'd144, 15'd32767, 15'd1, 15'd96, 15'd0};
        logic [RATE_W-1:0] rate_set[NUM_PHASES] = '{18'd44100, 18'd1000, 18'd192000,
                                                    18'd0, 18'd192000};
        int idle_set[NUM_PHASES]  = '{0, 84, 0, 24, 0};
        int stall_set[NUM_PHASES] = '{0, 0, 84, 24, 84};
        int count_set[NUM_PHASES] = '{40, 50, 50, 35, 30};
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        push       = 1'b0;
        pop        = 1'b0;
        i_item     = '0;
        pr_tpq         = TPQ_RESET;
        pr_rate        = RATE_RESET;
        pr_whole       = '0;
        pr_resid       = '0;
        pr_tempo       = TEMPO_RESET;
        pr_track_bytes = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                wait_idle();
                write_reg(CFG_TPQ, CFG_DATA_W'(tpq_set[ph]));
                write_reg(CFG_RATE, CFG_DATA_W'(rate_set[ph]));
            end
            send_idle_pct  = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            if (ph == 0)
                queue_directed_events();
            queue_random_events(count_set[ph]);
        end
        wait_idle();

        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/mese_pkg.sv
hw/rtl/mese_front.sv
hw/rtl/mese_muldiv.sv
hw/rtl/mese_back.sv
hw/rtl/midi_event_stream_encoder_core.sv
hw/rtl/mese_checker.sv
verif/tb_top.sv
